@@ sv/dad_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dad_pkg: shared types and constants for the date adder
// Beat structures, status and register codes, month length helper.
// ----------------------------------------------------------------------------
package dad_pkg;

    localparam int ADD_BITS  = 16;
    localparam int YEAR_BITS = 12;

    // width of the running day count (day plus days to add)
    localparam int DCNT_BITS = ADD_BITS + 1;

    // year / 25 by reciprocal: exact floor for any 12-bit year
    localparam int Y25_SHIFT      = 21;
    localparam int Y25_RECIP_BITS = 17;
    localparam logic [Y25_RECIP_BITS-1:0] Y25_RECIP =
        Y25_RECIP_BITS'((2 ** Y25_SHIFT + 24) / 25);
    localparam int Y25_Q_BITS = YEAR_BITS - 4;
    localparam int Y25_PROD_BITS = YEAR_BITS + Y25_RECIP_BITS;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_INVALID = 2'd1;
    localparam logic [1:0] STATUS_RANGE   = 2'd2;

    localparam logic [0:0] CFG_MIN_YEAR = 1'd0;
    localparam logic [0:0] CFG_MAX_YEAR = 1'd1;

    localparam logic [YEAR_BITS-1:0] MIN_YEAR_RST = YEAR_BITS'(1582);
    localparam logic [YEAR_BITS-1:0] MAX_YEAR_RST = YEAR_BITS'(2024);

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    typedef struct packed {
        logic [4:0]           start_day;
        logic [3:0]           start_month;
        logic [YEAR_BITS-1:0] start_year;
        logic [ADD_BITS-1:0]  days_to_add;
    } t_in;

    typedef struct packed {
        logic [4:0]           result_day;
        logic [3:0]           result_month;
        logic [YEAR_BITS-1:0] result_year;
        logic [1:0]           status;
    } t_out;

    // Gregorian month length; zero for a month code outside 1..12
    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        unique case (month)
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            MONTH_FEB:               len = leap ? 5'd29 : 5'd28;
            4'd1, 4'd3, 4'd5, 4'd7,
            4'd8, 4'd10, 4'd12:      len = 5'd31;
            default:                 len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

@@ sv/date_add_days_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_add_days_top: Gregorian date plus a day count
// Checks the start date, then walks it forward one month per cycle.
// ----------------------------------------------------------------------------
// Run time: grows with each month stepped; the single month-step subtractor
//   walks the date one month at a time.
// Throughput: one item at a time; the next beat is taken once the result has
//   moved into the output register, even if that beat is not yet taken.
// Reset: synchronous, active low; clears the sequencer and output valid and
//   loads min_year 1582 and max_year 2024.
module date_add_days_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // item channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  dad_pkg::t_in                  i_in_data,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output dad_pkg::t_out                 o_out_data,
    // register writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [0:0]                    i_cfg_index,
    input  logic [dad_pkg::YEAR_BITS-1:0] i_cfg_data
);

    localparam int YB = dad_pkg::YEAR_BITS;
    localparam int DB = dad_pkg::DCNT_BITS;
    localparam int QB = dad_pkg::Y25_Q_BITS;

    // sequencer codes
    localparam logic [1:0] S_IDLE  = 2'd0;  // waiting for a beat
    localparam logic [1:0] S_CHECK = 2'd1;  // finish year mod 25, validate
    localparam logic [1:0] S_WALK  = 2'd2;  // one month per cycle
    localparam logic [1:0] S_DONE  = 2'd3;  // hand result to output reg

    logic [1:0]              r_state, n_state;
    logic [YB-1:0]           r_min_year, r_max_year;
    logic [4:0]              r_day;
    logic [3:0]              r_month, n_month;
    logic [YB-1:0]           r_year, n_year;
    logic [dad_pkg::ADD_BITS-1:0] r_add;
    logic [QB-1:0]           r_q25;
    logic [4:0]              r_y25, n_y25;
    logic [DB-1:0]           r_dcnt, n_dcnt;
    logic [1:0]              r_status, n_status;
    logic                    r_out_valid;
    dad_pkg::t_out           r_out;

    logic                    in_acc;
    logic                    out_free;
    logic [dad_pkg::Y25_PROD_BITS-1:0] q_prod;
    logic [YB-1:0]           q_times25;
    logic [YB-1:0]           rem_full;
    logic [4:0]              rem25;
    logic [4:0]              cur_y25;
    logic                    leap;
    logic [4:0]              mlen;
    logic                    date_ok;
    logic [YB:0]             year_inc;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;

    // year / 25 via reciprocal multiply, registered before use
    assign q_prod = dad_pkg::Y25_PROD_BITS'(i_in_data.start_year) *
                    dad_pkg::Y25_PROD_BITS'(dad_pkg::Y25_RECIP);

    // remainder: year - 25q, 25q done as shifts and adds
    assign q_times25 = (YB'(r_q25) << 4) + (YB'(r_q25) << 3) + YB'(r_q25);
    assign rem_full  = r_year - q_times25;
    assign rem25     = rem_full[4:0];

    // in CHECK the fresh remainder is used, afterwards the running copy
    assign cur_y25 = (r_state == S_CHECK) ? rem25 : r_y25;

    // leap: div by 4 and not by 100, or div by 400 (100 = 4*25, 400 = 16*25)
    assign leap = (r_year[1:0] == 2'b00) && ((cur_y25 != 5'd0) || (r_year[3:0] == 4'b0000));
    assign mlen = dad_pkg::month_len(r_month, leap);

    assign date_ok = (r_year >= r_min_year) && (r_year <= r_max_year) &&
                     (r_day != 5'd0) && (r_day <= mlen);

    assign year_inc = {1'b0, r_year} + {{YB{1'b0}}, 1'b1};

    always_comb begin
        n_state  = r_state;
        n_month  = r_month;
        n_year   = r_year;
        n_y25    = r_y25;
        n_dcnt   = r_dcnt;
        n_status = r_status;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_y25 = rem25;
                // month_len gives 0 for a bad month, so the day test fails too
                if (date_ok) begin
                    n_dcnt  = DB'(r_day) + DB'(r_add);
                    n_state = S_WALK;
                end else begin
                    n_status = dad_pkg::STATUS_INVALID;
                    n_state  = S_DONE;
                end
            end
            S_WALK: begin
                if (r_dcnt > DB'(mlen)) begin
                    n_dcnt = r_dcnt - DB'(mlen);
                    if (r_month == dad_pkg::MONTH_DEC) begin
                        n_month = dad_pkg::MONTH_JAN;
                        n_year  = year_inc[YB-1:0];
                        n_y25   = (r_y25 == 5'd24) ? 5'd0 : r_y25 + 5'd1;
                        if (year_inc > {1'b0, r_max_year}) begin
                            n_status = dad_pkg::STATUS_RANGE;
                            n_state  = S_DONE;
                        end
                    end else begin
                        n_month = r_month + 4'd1;
                    end
                end else begin
                    n_status = dad_pkg::STATUS_OK;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_min_year  <= dad_pkg::MIN_YEAR_RST;
            r_max_year  <= dad_pkg::MAX_YEAR_RST;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    dad_pkg::CFG_MIN_YEAR: r_min_year <= i_cfg_data;
                    dad_pkg::CFG_MAX_YEAR: r_max_year <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_day   <= i_in_data.start_day;
            r_month <= i_in_data.start_month;
            r_year  <= i_in_data.start_year;
            r_add   <= i_in_data.days_to_add;
            r_q25   <= q_prod[dad_pkg::Y25_SHIFT +: QB];
        end else begin
            r_month <= n_month;
            r_year  <= n_year;
        end
        r_y25    <= n_y25;
        r_dcnt   <= n_dcnt;
        r_status <= n_status;
        if (r_state == S_DONE && out_free) begin
            r_out.status <= r_status;
            if (r_status == dad_pkg::STATUS_OK) begin
                r_out.result_day   <= r_dcnt[4:0];
                r_out.result_month <= r_month;
                r_out.result_year  <= r_year;
            end else begin
                r_out.result_day   <= '0;
                r_out.result_month <= '0;
                r_out.result_year  <= '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ sv/dad_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dad_chk: port-level checks for the date adder
// Watches the item and result channels of the top level.
// ----------------------------------------------------------------------------
module dad_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input dad_pkg::t_out o_out_data
);

    // a held result beat keeps its contents
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    // one item at a time: busy right after a beat is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("item channel not busy after accept");

    // failed results carry an all-zero date
    a_zero_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != dad_pkg::STATUS_OK |->
        o_out_data.result_day == 5'd0 && o_out_data.result_month == 4'd0 &&
        o_out_data.result_year == '0)
        else $error("non-zero date on failed result");

    // good results carry a nonzero day and a month in 1..12
    a_ok_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == dad_pkg::STATUS_OK |->
        o_out_data.result_day != 5'd0 && o_out_data.result_month != 4'd0 &&
        o_out_data.result_month <= dad_pkg::MONTH_DEC)
        else $error("bad date on ok result");

    // no undefined status code
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.status == dad_pkg::STATUS_OK ||
        o_out_data.status == dad_pkg::STATUS_INVALID ||
        o_out_data.status == dad_pkg::STATUS_RANGE)
        else $error("undefined status code");

endmodule

bind date_add_days_top dad_chk u_dad_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for date_add_days_top
// Sends dated beats with day counts, predicts each resulting date and
// status in the bench, and compares every result beat in order.
// ----------------------------------------------------------------------------
module testbench;

    import dad_pkg::*;

    // guard against a hung block: far beyond the slowest correct run
    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    // the block is back in idle by the time its last result beat is taken
    localparam int unsigned SETTLE_CYCLES = 4;

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in                  i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out                 o_out_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [0:0]           i_cfg_index = CFG_MIN_YEAR;
    logic [YEAR_BITS-1:0] i_cfg_data  = '0;

    // bench copy of the year limits, updated as each write is taken
    int unsigned lim_min = MIN_YEAR_RST;
    int unsigned lim_max = MAX_YEAR_RST;

    t_out        expected_dates[$];
    int unsigned dates_sent    = 0;
    int unsigned dates_checked = 0;
    int unsigned ok_seen       = 0;
    int unsigned invalid_seen  = 0;
    int unsigned range_seen    = 0;
    int unsigned limit_writes  = 0;
    int unsigned error_count   = 0;
    int unsigned cycle_count   = 0;
    int unsigned stall_left    = 0;
    bit          idle_on       = 1'b1;

    date_add_days_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Calendar predictor
    // ------------------------------------------------------------------

    // Gregorian length of a month; proleptic for every year, year 0 leap
    function automatic int unsigned days_in_month(int unsigned month, int unsigned year);
        bit leap;
        leap = ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
        case (month)
            4, 6, 9, 11:              return 30;
            MONTH_FEB:                return leap ? 29 : 28;
            1, 3, 5, 7, 8, 10, 12:    return 31;
            default:                  return 0;
        endcase
    endfunction

    // Walks the date forward month by month, as the block does
    function automatic t_out add_days_predict(t_in item);
        t_out        res;
        int unsigned day_cnt;
        int unsigned month;
        int unsigned year;
        int unsigned len;
        res   = '0;
        month = item.start_month;
        year  = item.start_year;
        len   = days_in_month(month, year);
        if (year < lim_min || year > lim_max || len == 0 ||
            item.start_day == 0 || item.start_day > len) begin
            res.status = STATUS_INVALID;
            return res;
        end
        day_cnt = item.start_day + item.days_to_add;
        while (day_cnt > len) begin
            day_cnt -= len;
            month++;
            if (month > MONTH_DEC) begin
                month = MONTH_JAN;
                year++;
                // stop as soon as the walk leaves the permitted years
                if (year > lim_max) begin
                    res.status = STATUS_RANGE;
                    return res;
                end
            end
            len = days_in_month(month, year);
        end
        res.result_day   = day_cnt[4:0];
        res.result_month = month[3:0];
        res.result_year  = year[YEAR_BITS-1:0];
        res.status       = STATUS_OK;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stall bursts and in-order checking
    // ------------------------------------------------------------------

    // Random bursts of stalled cycles; none while idling is off
    always @(negedge i_clk) begin
        if (!i_rst_n || !idle_on) begin
            stall_left = 0;
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 16);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_dates.size() == 0) begin
                $display("%0t: result beat with nothing expected, expected none, actual %p",
                         $time, o_out_data);
                error_count++;
            end else begin
                want = expected_dates.pop_front();
                check_field("result_day",   want.result_day,   o_out_data.result_day);
                check_field("result_month", want.result_month, o_out_data.result_month);
                check_field("result_year",  want.result_year,  o_out_data.result_year);
                check_field("status",       want.status,       o_out_data.status);
                dates_checked++;
                case (want.status)
                    STATUS_OK:      ok_seen++;
                    STATUS_INVALID: invalid_seen++;
                    default:        range_seen++;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers; every task starts and ends on a falling edge
    // ------------------------------------------------------------------

    function automatic t_in mk_date(int unsigned day, int unsigned month,
                                    int unsigned year, int unsigned add);
        t_in item;
        item.start_day   = day[4:0];
        item.start_month = month[3:0];
        item.start_year  = year[YEAR_BITS-1:0];
        item.days_to_add = add[ADD_BITS-1:0];
        return item;
    endfunction

    // Mostly well-formed dates inside the limits, the rest raw noise.
    // Day counts are kept short on the whole, with the odd full-width one.
    function automatic t_in random_date();
        t_in         item;
        int unsigned year;
        int unsigned month;
        item = t_in'({$urandom, $urandom});
        if ($urandom_range(0, 9) < 8) begin
            year  = (lim_min <= lim_max) ? $urandom_range(lim_min, lim_max) : $urandom;
            month = $urandom_range(1, 12);
            item.start_year  = year[YEAR_BITS-1:0];
            item.start_month = month[3:0];
            item.start_day   = 5'($urandom_range(1, days_in_month(month, year[YEAR_BITS-1:0])));
        end
        case ($urandom_range(0, 15))
            0:       item.days_to_add = ADD_BITS'($urandom);
            1:       item.days_to_add = '0;
            2, 3:    item.days_to_add = ADD_BITS'($urandom_range(0, 31));
            default: item.days_to_add = ADD_BITS'($urandom_range(0, 800));
        endcase
        return item;
    endfunction

    // One input beat; valid is left high so a following beat can go straight on
    task automatic send_date(input t_in item);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_dates.push_back(add_days_predict(item));
        dates_sent++;
        @(negedge i_clk);
    endtask

    // Drop valid and wait for every expected result, then a short margin
    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_dates.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Writes both limits back to back; only called with the block idle
    task automatic set_limits(input int unsigned lo, input int unsigned hi);
        for (int k = 0; k < 2; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= (k == 0) ? CFG_MIN_YEAR : CFG_MAX_YEAR;
            i_cfg_data  <= (k == 0) ? lo[YEAR_BITS-1:0] : hi[YEAR_BITS-1:0];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            if (k == 0)
                lim_min = lo[YEAR_BITS-1:0];
            else
                lim_max = hi[YEAR_BITS-1:0];
            limit_writes++;
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset limits 1582..2024: leap rules, month ends, bad fields, overflow
    task automatic test_calendar_edges();
        send_date(mk_date(1, 1, 1582, 0));
        send_date(mk_date(31, 12, 2023, 1));      // year rollover
        send_date(mk_date(28, 2, 2000, 1));       // leap by 400
        send_date(mk_date(28, 2, 1900, 1));       // century, not leap
        send_date(mk_date(29, 2, 2001, 0));       // no 29th in a plain year
        send_date(mk_date(31, 4, 2000, 0));       // 30-day month overrun
        send_date(mk_date(0, 6, 2000, 5));        // day zero
        send_date(mk_date(10, 0, 2000, 5));       // month zero
        send_date(mk_date(10, 13, 2000, 5));      // month past December
        send_date(mk_date(5, 5, 1581, 0));        // below min
        send_date(mk_date(5, 5, 2025, 0));        // above max
        send_date(mk_date(31, 12, 2024, 1));      // walks past max_year
        send_date(mk_date(1, 1, 2024, 65535));    // full count, out of range
        send_date(mk_date(1, 1, 1582, 65535));    // full count, lands in range
        send_date(mk_date(31, 15, 4095, 65535));  // every field at its top
        settle();
    endtask

    // Widest limits: year zero is leap, top year cannot roll over
    task automatic test_full_year_span();
        set_limits(0, 4095);
        send_date(mk_date(1, 1, 0, 59));          // lands on 29 Feb, year 0
        send_date(mk_date(29, 2, 4000, 0));
        send_date(mk_date(29, 2, 4001, 0));
        send_date(mk_date(1, 1, 4095, 364));
        send_date(mk_date(1, 1, 4095, 365));
        send_date(mk_date(31, 12, 4095, 1));
        settle();
    endtask

    // min above max: nothing is a valid year
    task automatic test_crossed_limits();
        set_limits(2025, 2024);
        send_date(mk_date(1, 1, 2024, 0));
        send_date(mk_date(1, 1, 2025, 0));
        repeat (4) send_date(random_date());
        settle();
    endtask

    // Single-year windows at both extremes
    task automatic test_single_year();
        set_limits(0, 0);
        send_date(mk_date(1, 1, 0, 365));         // ends on 31 Dec exactly
        send_date(mk_date(1, 1, 0, 366));
        send_date(mk_date(1, 1, 1, 0));
        settle();
        set_limits(4095, 4095);
        send_date(mk_date(31, 12, 4095, 0));
        settle();
    endtask

    // Random limits per phase, random dates with idling on both sides
    task automatic test_random_limits();
        int unsigned lo;
        int unsigned hi;
        for (int phase = 0; phase < 6; phase++) begin
            settle();
            case ($urandom_range(0, 3))
                0: begin
                    lo = $urandom_range(1, 4095);
                    hi = $urandom_range(0, lo - 1);
                end
                1: begin
                    lo = $urandom_range(0, 4095);
                    hi = (lo + 3 > 4095) ? 4095 : lo + $urandom_range(0, 3);
                end
                default: begin
                    lo = $urandom_range(0, 2047);
                    hi = $urandom_range(lo, 4095);
                end
            endcase
            set_limits(lo, hi);
            // one phase runs flat out for a stretch with no idling
            idle_on = (phase != 3);
            repeat (35) send_date(random_date());
        end
        settle();
    endtask

    // Closing stretch: reset limits again, back-to-back beats, no stalls
    task automatic test_steady_stream();
        set_limits(MIN_YEAR_RST, MAX_YEAR_RST);
        idle_on = 1'b0;
        repeat (30) send_date(random_date());
        settle();
    endtask

    // ------------------------------------------------------------------
    // Run control
    // ------------------------------------------------------------------

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("testbench: timed out after %0d cycles, %0d results outstanding",
                 cycle_count, expected_dates.size());
        $display("testbench: FAIL");
        $finish;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_calendar_edges();
        test_full_year_span();
        test_crossed_limits();
        test_single_year();
        test_random_limits();
        test_steady_stream();

        $display("testbench: %0d dates sent, %0d checked (%0d ok, %0d invalid, %0d out of range)",
                 dates_sent, dates_checked, ok_seen, invalid_seen, range_seen);
        $display("testbench: %0d limit writes, %0d cycles, %0d errors",
                 limit_writes, cycle_count, error_count);
        if (error_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
